/* rtl/efic_pkg.sv */
// Shared constants and types for the event frame integrity checker.
// No dependencies; imported by the top level, efic_frame_check and the testbench.
`default_nettype none

package efic_pkg;

    localparam int POSITION_BITS_DEFAULT = 16;

    localparam logic [15:0] HEAD_MARK         = 16'h805a;
    localparam logic [15:0] TAIL_MARK         = 16'h8069;
    localparam logic [15:0] MIN_WORDS         = 16'd9;
    localparam logic [15:0] EVENT_WORDS_RESET = 16'd64;

    // Per-event verdict, as handed from the frame checker to the result register
    typedef struct packed {
        logic        head_error;
        logic        tail_error;
        logic        id_error;
        logic        pattern_error;
        logic [15:0] trigger_id;
    } efic_result_t;

endpackage

`default_nettype wire

/* rtl/event_frame_integrity_checker.sv */
// Event frame integrity checker: top level with input and result registers.
// Depends on efic_pkg and efic_frame_check.
//
// Usage:
//   Words of the event stream enter on data_word with word_valid/word_stall; a beat
//   moves at a clock edge where valid is high and stall is low. One result beat per
//   event leaves on result_valid/result_stall carrying the four error flags and the
//   trigger id of that event.
//   The event length is written through cfg_write/cfg_data while the block is idle;
//   values below 9 act as 9. Reset loads a length of 64.
//   Throughput: one word per cycle unless a last word stalls, set by the single word
//   register that feeds the checks and the state update; a last word's verdict goes
//   from the word register into the result register, which drives result_valid.
//   When result_stall holds a pending result, non-last words keep flowing; the last
//   word of the next event waits in the word register and word_stall rises.
//   Reset clears the word position, the trigger id history and both valid registers;
//   the first event after reset never reports an id error.
`default_nettype none

module event_frame_integrity_checker
    import efic_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [15:0] cfg_data,
    input  wire logic        word_valid,
    output logic             word_stall,
    input  wire logic [31:0] data_word,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic             head_error,
    output logic             tail_error,
    output logic             id_error,
    output logic             pattern_error,
    output logic [15:0]      trigger_id
);

    logic [15:0]  event_words_reg;
    logic         word_valid_reg;
    logic [31:0]  word_reg;
    logic         result_valid_reg;
    efic_result_t result_reg;

    efic_result_t check_result;
    logic         check_last;
    logic         out_free;
    logic         step;
    logic         word_accept;

    efic_frame_check #(
        .POSITION_BITS (POSITION_BITS)
    ) u_frame_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .data_word   (word_reg),
        .event_words (event_words_reg),
        .last        (check_last),
        .result      (check_result)
    );

    assign out_free    = !result_valid_reg || !result_stall;
    assign step        = word_valid_reg && (!check_last || out_free);
    assign word_stall  = word_valid_reg && !step;
    assign word_accept = word_valid && !word_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            event_words_reg  <= EVENT_WORDS_RESET;
            word_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                event_words_reg <= cfg_data;
            end
            if (word_accept)
            begin
                word_valid_reg <= 1'b1;
            end
            else if (step)
            begin
                word_valid_reg <= 1'b0;
            end
            if (step && check_last)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (word_accept)
        begin
            word_reg <= data_word;
        end
        // Load the verdict on the last word; hold it while stalled
        if (step && check_last)
        begin
            result_reg <= check_result;
        end
    end

    assign result_valid  = result_valid_reg;
    assign head_error    = result_reg.head_error;
    assign tail_error    = result_reg.tail_error;
    assign id_error      = result_reg.id_error;
    assign pattern_error = result_reg.pattern_error;
    assign trigger_id    = result_reg.trigger_id;

endmodule

`default_nettype wire

/* rtl/efic_frame_check.sv */
// Per-word frame checks: position counter, trigger id tracking and data pattern flags.
// Depends on efic_pkg.
`default_nettype none

module efic_frame_check
    import efic_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         step,
    input  wire logic [31:0]  data_word,
    input  wire logic [15:0]  event_words,
    output logic              last,
    output efic_result_t      result
);

    localparam int CMP_W = (POSITION_BITS > 16 ? POSITION_BITS : 16) + 1;

    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [15:0]              last_id_reg, last_id_next;
    logic                     id_seen_reg, id_seen_next;
    logic [15:0]              prev_half_reg, prev_half_next;
    logic                     head_flag_reg, head_flag_next;
    logic                     id_flag_reg, id_flag_next;
    logic                     pattern_flag_reg, pattern_flag_next;
    logic [15:0]              cur_id_reg, cur_id_next;

    logic [15:0]      hi;
    logic [15:0]      lo;
    logic [15:0]      len;
    logic [CMP_W-1:0] pos_w;
    logic [CMP_W-1:0] len_w;
    logic             at_head;
    logic             at_id;
    logic             at_first_data;
    logic             in_data;

    assign hi  = data_word[31:16];
    assign lo  = data_word[15:0];
    assign len = (event_words < MIN_WORDS) ? MIN_WORDS : event_words;

    assign pos_w = CMP_W'(pos_reg);
    assign len_w = CMP_W'(len);

    assign last          = (pos_w + CMP_W'(1)) >= len_w;
    assign at_head       = (pos_reg == '0);
    assign at_id         = (pos_reg == POSITION_BITS'(1));
    assign at_first_data = (pos_w == CMP_W'(4));
    assign in_data       = (pos_w >= CMP_W'(4)) && (pos_w <= (len_w - CMP_W'(5)));

    always_comb
    begin
        pos_next          = pos_reg;
        last_id_next      = last_id_reg;
        id_seen_next      = id_seen_reg;
        prev_half_next    = prev_half_reg;
        head_flag_next    = head_flag_reg;
        id_flag_next      = id_flag_reg;
        pattern_flag_next = pattern_flag_reg;
        cur_id_next       = cur_id_reg;

        if (step)
        begin
            if (at_head)
            begin
                head_flag_next    = (hi != HEAD_MARK);
                id_flag_next      = 1'b0;
                pattern_flag_next = 1'b0;
            end
            if (at_id)
            begin
                cur_id_next  = lo;
                // Compare without wrap: an id of zero never follows 0xffff
                id_flag_next = id_seen_reg
                    && ({1'b0, lo} != ({1'b0, last_id_reg} + 17'd1));
                last_id_next = lo;
                id_seen_next = 1'b1;
            end
            if (in_data)
            begin
                if (!at_first_data && (({1'b0, prev_half_reg} + 17'd1) != {1'b0, hi}))
                begin
                    pattern_flag_next = 1'b1;
                end
                if (({1'b0, hi} + 17'd1) != {1'b0, lo})
                begin
                    pattern_flag_next = 1'b1;
                end
                prev_half_next = lo;
            end
            pos_next = last ? '0 : pos_reg + POSITION_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg          <= '0;
            last_id_reg      <= '0;
            id_seen_reg      <= 1'b0;
            prev_half_reg    <= '0;
            head_flag_reg    <= 1'b0;
            id_flag_reg      <= 1'b0;
            pattern_flag_reg <= 1'b0;
            cur_id_reg       <= '0;
        end
        else
        begin
            pos_reg          <= pos_next;
            last_id_reg      <= last_id_next;
            id_seen_reg      <= id_seen_next;
            prev_half_reg    <= prev_half_next;
            head_flag_reg    <= head_flag_next;
            id_flag_reg      <= id_flag_next;
            pattern_flag_reg <= pattern_flag_next;
            cur_id_reg       <= cur_id_next;
        end
    end

    // Head, id and pattern words never share a beat with the last word
    assign result.head_error    = head_flag_reg;
    assign result.tail_error    = (lo != TAIL_MARK);
    assign result.id_error      = id_flag_reg;
    assign result.pattern_error = pattern_flag_reg;
    assign result.trigger_id    = cur_id_reg;

endmodule

`default_nettype wire

/* rtl/efic_checker.sv */
// Port-level assertions for the event frame integrity checker, bound to its top level.
// Depends on event_frame_integrity_checker.
`default_nettype none

module efic_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        word_stall,
    input  wire logic        result_valid,
    input  wire logic        result_stall,
    input  wire logic        head_error,
    input  wire logic        tail_error,
    input  wire logic        id_error,
    input  wire logic        pattern_error,
    input  wire logic [15:0] trigger_id
);

    // Input side only backs up when a result is pending and blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        word_stall |-> (result_valid && result_stall))
        else $error("word_stall without a blocked result");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> (!result_valid && !word_stall))
        else $error("result_valid or word_stall active in reset");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(trigger_id)
            && $stable(head_error) && $stable(tail_error)
            && $stable(id_error) && $stable(pattern_error)))
        else $error("stalled result beat changed");

endmodule

bind event_frame_integrity_checker efic_checker u_efic_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .word_stall    (word_stall),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .head_error    (head_error),
    .tail_error    (tail_error),
    .id_error      (id_error),
    .pattern_error (pattern_error),
    .trigger_id    (trigger_id)
);

`default_nettype wire

/* tb/sv/tb_event_frame_integrity_checker.sv */
// Testbench for event_frame_integrity_checker: word driver, verdict predictor and
// result monitor, with random idling on both channels. Depends on efic_pkg and the RTL.
module tb_event_frame_integrity_checker;
    import efic_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STIM_ITEMS    = 1650;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b1;
    logic        cfg_write = 1'b0;
    logic [15:0] cfg_data = 16'd0;
    logic        word_valid = 1'b0;
    logic        word_stall;
    logic [31:0] data_word = 32'd0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic        head_error;
    logic        tail_error;
    logic        id_error;
    logic        pattern_error;
    logic [15:0] trigger_id;

    event_frame_integrity_checker DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .word_valid    (word_valid),
        .word_stall    (word_stall),
        .data_word     (data_word),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .head_error    (head_error),
        .tail_error    (tail_error),
        .id_error      (id_error),
        .pattern_error (pattern_error),
        .trigger_id    (trigger_id)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    logic [31:0]  pending_words[$];
    efic_result_t verdicts_due[$];
    int           mismatches = 0;
    int           word_idle_pct = 0;
    int           result_idle_pct = 0;

    // Verdict predictor state
    logic [15:0] frame_len_cfg = EVENT_WORDS_RESET;
    logic [15:0] pos_in_frame = 16'd0;
    logic [15:0] prev_id = 16'd0;
    logic        id_known = 1'b0;
    logic [15:0] prev_half = 16'd0;
    logic        head_bad = 1'b0;
    logic        id_bad = 1'b0;
    logic        pattern_bad = 1'b0;
    logic [15:0] frame_id = 16'd0;

    // Stimulus generator state: where the block will be in its frame
    int          gen_len = 64;
    int          gen_pos = 0;
    int          stim_count = 0;
    logic [15:0] next_id = 16'd0;

    task automatic judge_word(input logic [31:0] w);
        logic [15:0]  hi;
        logic [15:0]  lo;
        logic [15:0]  len;
        logic         last;
        efic_result_t v;
        hi = w[31:16];
        lo = w[15:0];
        len = (frame_len_cfg < MIN_WORDS) ? MIN_WORDS : frame_len_cfg;
        last = ({1'b0, pos_in_frame} + 17'd1) >= {1'b0, len};
        if (pos_in_frame == 16'd0)
        begin
            head_bad = (hi != HEAD_MARK);
            id_bad = 1'b0;
            pattern_bad = 1'b0;
        end
        if (pos_in_frame == 16'd1)
        begin
            frame_id = lo;
            // no wrap: an id of zero after 0xffff is an error
            id_bad = id_known && ({1'b0, lo} != {1'b0, prev_id} + 17'd1);
            prev_id = lo;
            id_known = 1'b1;
        end
        if (pos_in_frame >= 16'd4 && pos_in_frame <= len - 16'd5)
        begin
            if (pos_in_frame != 16'd4 && {1'b0, prev_half} + 17'd1 != {1'b0, hi})
                pattern_bad = 1'b1;
            if ({1'b0, hi} + 17'd1 != {1'b0, lo})
                pattern_bad = 1'b1;
            prev_half = lo;
        end
        if (last)
        begin
            v.head_error    = head_bad;
            v.tail_error    = (lo != TAIL_MARK);
            v.id_error      = id_bad;
            v.pattern_error = pattern_bad;
            v.trigger_id    = frame_id;
            verdicts_due = {verdicts_due, v};
            pos_in_frame = 16'd0;
        end
        else
            pos_in_frame = pos_in_frame + 16'd1;
    endtask

    task automatic report_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    function automatic logic [31:0] filler();
        case ($urandom_range(15, 0))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_word(input logic [31:0] w);
        pending_words = {pending_words, w};
        stim_count++;
        if (gen_pos + 1 >= gen_len)
            gen_pos = 0;
        else
            gen_pos++;
    endtask

    // Pad with filler until the block is back at word 0
    task automatic realign();
        while (gen_pos != 0)
            queue_word(filler());
    endtask

    // Queue the first cut words of a frame of len words with a rising pattern
    task automatic queue_frame(input int len, input logic [15:0] head_hi,
                               input logic [15:0] id, input logic [15:0] base,
                               input logic [15:0] tail_lo, input int flip_at,
                               input logic [31:0] flip_mask, input int cut);
        logic [31:0] w;
        logic [15:0] half;
        for (int k = 0; k < cut; k++)
        begin
            half = base + 16'(2 * (k - 4));
            if (k == 0)
                w = {head_hi, 16'($urandom)};
            else if (k == 1)
                w = {16'($urandom), id};
            else if (k == len - 1)
                w = {16'($urandom), tail_lo};
            else if (k >= 4 && k <= len - 5)
                w = {half, half + 16'd1};
            else
                w = filler();
            if (k == flip_at)
                w = w ^ flip_mask;
            queue_word(w);
        end
    endtask

    task automatic write_length(input logic [15:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data <= value;
        frame_len_cfg = value;
        gen_len = (value < MIN_WORDS) ? int'(MIN_WORDS) : int'(value);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Hold until every word is taken and every verdict has come back
    task automatic wait_idle();
        while (pending_words.size() != 0 || word_valid || verdicts_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_good_frame(input bit faulty);
        int          flip_at;
        logic [31:0] flip_mask;
        flip_at = faulty ? $urandom_range(gen_len - 1, 0) : -1;
        flip_mask = 32'd1 << $urandom_range(31, 0);
        queue_frame(gen_len, HEAD_MARK, next_id, 16'($urandom), TAIL_MARK,
                    flip_at, flip_mask, gen_len);
        next_id = next_id + 16'd1;
    endtask

    // Word driver
    int word_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_valid <= 1'b0;
            word_gap <= 0;
        end
        else if (!word_valid || !word_stall)
        begin
            if (word_gap > 0)
            begin
                word_gap <= word_gap - 1;
                word_valid <= 1'b0;
            end
            else if (pending_words.size() > 0 && $urandom_range(99, 0) < word_idle_pct)
            begin
                word_gap <= $urandom_range(7, 0);
                word_valid <= 1'b0;
            end
            else if (pending_words.size() > 0)
            begin
                data_word <= pending_words.pop_front();
                word_valid <= 1'b1;
            end
            else
                word_valid <= 1'b0;
        end
    end

    // Result stall driver
    int hold_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else if ($urandom_range(99, 0) < result_idle_pct)
        begin
            hold_left <= $urandom_range(7, 0);
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    // Predict on every accepted word beat
    always @(posedge clk)
    begin
        if (rst_n && word_valid && !word_stall)
            judge_word(data_word);
    end

    // Check every accepted result beat against the oldest verdict
    always @(posedge clk)
    begin
        efic_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (verdicts_due.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, actual %b%b%b%b id %0h",
                         $time, head_error, tail_error, id_error, pattern_error, trigger_id);
                mismatches++;
            end
            else
            begin
                want = verdicts_due.pop_front();
                report_field("head_error", 16'(want.head_error), 16'(head_error));
                report_field("tail_error", 16'(want.tail_error), 16'(tail_error));
                report_field("id_error", 16'(want.id_error), 16'(id_error));
                report_field("pattern_error", 16'(want.pattern_error), 16'(pattern_error));
                report_field("trigger_id", want.trigger_id, trigger_id);
            end
        end
    end

    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((word_valid && !word_stall) || (result_valid && !result_stall) || cfg_write)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int  pick;
        bit  big_done;
        big_done = 1'b0;
        rst_n <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset length, first frame: no id check
        queue_frame(64, HEAD_MARK, 16'd5, 16'h1000, TAIL_MARK, -1, 32'd0, 64);
        wait_idle();
        // Zero length acts as 9; every flag set, trigger id zero
        write_length(16'd0);
        queue_frame(9, 16'h1234, 16'd0, 16'h2000, 16'h0000, 4, 32'h0000_0001, 9);
        wait_idle();
        // Half-word wrap from 0xffff to 0x0000
        write_length(16'd10);
        queue_frame(10, HEAD_MARK, 16'd1, 16'hfffe, TAIL_MARK, -1, 32'd0, 10);
        wait_idle();
        next_id = 16'd2;
        stim_count = 0;

        while (stim_count < STIM_ITEMS)
        begin
            if (stim_count > STIM_ITEMS - 300)
            begin
                word_idle_pct = 0;
                result_idle_pct = 0;
            end
            else
            begin
                word_idle_pct = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(40, 5);
                result_idle_pct = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(40, 5);
            end

            // Open a frame at the largest length; the next length closes it
            if (!big_done && stim_count > STIM_ITEMS / 2)
            begin
                realign();
                wait_idle();
                write_length(16'hffff);
                queue_frame(gen_len, HEAD_MARK, next_id, 16'($urandom), TAIL_MARK,
                            -1, 32'd0, $urandom_range(64, 8));
                next_id = next_id + 16'd1;
                wait_idle();
                big_done = 1'b1;
            end

            pick = $urandom_range(99, 0);
            if (pick < 20)
                write_length(16'($urandom_range(8, 0)));
            else if (pick < 85)
                write_length(16'($urandom_range(24, 9)));
            else
                write_length(16'($urandom_range(120, 25)));
            // A frame left open by the last phase ends under the new length
            realign();
            if ($urandom_range(9, 0) == 0)
                next_id = 16'hfffe;

            repeat ($urandom_range(8, 2))
            begin
                pick = $urandom_range(99, 0);
                if (pick < 70)
                    queue_good_frame($urandom_range(3, 0) == 0);
                else if (pick < 85)
                begin
                    queue_frame(gen_len, HEAD_MARK, next_id, 16'($urandom), TAIL_MARK,
                                -1, 32'd0, $urandom_range(gen_len - 1, 1));
                    next_id = next_id + 16'd1;
                    realign();
                end
                else
                begin
                    repeat ($urandom_range(2 * gen_len, 1))
                        queue_word(filler());
                    realign();
                end
            end
            // Leave a frame open so the next length takes effect mid-frame
            if ($urandom_range(9, 0) < 3)
                queue_frame(gen_len, HEAD_MARK, next_id, 16'($urandom), TAIL_MARK,
                            -1, 32'd0, $urandom_range(gen_len - 1, 1));
            wait_idle();
        end

        realign();
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        mismatches += verdicts_due.size();
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
